>>> rtl/u8u16_pkg.sv
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT = 16'hFFFD;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [5:0]  HI_PREFIX = 6'b110110;
	localparam logic [5:0]  LO_PREFIX = 6'b110111;

	// pending bytes, entry 0 is the oldest (the current lead)
	typedef logic [3:0][7:0] pend_t;

	// what the decode unit decides for the current lead
	typedef enum logic [2:0] {
		ACT_WAIT,
		ACT_BAD,
		ACT_CUT,
		ACT_ONE,
		ACT_PAIR
	} act_t;

	typedef struct packed {
		act_t        act;
		logic [2:0]  len;
		logic [15:0] unit_hi;
		logic [15:0] unit_lo;
	} dec_t;

	// sequence length announced by a lead byte, 0 for an invalid lead
	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] n;
		n = 3'd0;
		if (c <= 8'h7F) n = 3'd1;
		else if (c >= 8'hC2 && c <= 8'hDF) n = 3'd2;
		else if (c >= 8'hE0 && c <= 8'hEF) n = 3'd3;
		else if (c >= 8'hF0 && c <= 8'hF4) n = 3'd4;
		return n;
	endfunction

endpackage

>>> rtl/utf8_to_utf16_transcoder.sv
// Flow: an item is taken in ST_IDLE, then the decode unit runs one step per cycle on
// the oldest pending byte while the output is free; each step gives at most one unit,
// and the low surrogate of a pair is sent from ST_LO after the high one.
// No new item is taken until the buffered bytes are decoded or wait for more bytes,
// since the single decode unit serves them all; a stalled receiver holds this up.
// Reset (arst_n low, asynchronous) empties the byte buffer and the output register.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        unit_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_LO
	} state_t;

	state_t      state_q;
	pend_t       pend_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [15:0] lo_q;
	logic        out_valid_q;
	logic [15:0] unit_q;
	logic        unit_last_q;

	dec_t        dec;
	logic        out_free;
	logic        out_load;
	logic [2:0]  rem;

	u8u16_decode u_decode (
		.pend (pend_q),
		.cnt  (cnt_q),
		.last (last_q),
		.dec  (dec)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign rem       = cnt_q - dec.len;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign code_unit = unit_q;
	assign unit_last = unit_last_q;

	// a unit enters the output register this cycle
	assign out_load  = out_free && (state_q == ST_LO || (state_q == ST_STEP &&
		(dec.act == ACT_CUT || dec.act == ACT_BAD || dec.act == ACT_ONE ||
		dec.act == ACT_PAIR)));

	// sequencer, byte buffer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					// append the item to the buffer
					if (in_valid) begin
						pend_q[cnt_q[1:0]] <= in_byte;
						cnt_q              <= cnt_q + 3'd1;
						last_q             <= in_last;
						state_q            <= ST_STEP;
					end
				end
				ST_STEP: begin
					case (dec.act)
						ACT_WAIT: begin
							state_q <= ST_IDLE;
						end
						ACT_CUT: begin
							if (out_free) begin
								unit_q      <= REPL_UNIT;
								unit_last_q <= 1'b1;
								cnt_q       <= '0;
								state_q     <= ST_IDLE;
							end
						end
						ACT_BAD: begin
							// replace the lead, replay the rest as new leads
							if (out_free) begin
								unit_q      <= REPL_UNIT;
								unit_last_q <= last_q && cnt_q == 3'd1;
								pend_q      <= pend_t'(pend_q >> 8);
								cnt_q       <= cnt_q - 3'd1;
								if (cnt_q == 3'd1) state_q <= ST_IDLE;
							end
						end
						ACT_ONE: begin
							if (out_free) begin
								unit_q      <= dec.unit_hi;
								unit_last_q <= last_q && rem == 3'd0;
								pend_q      <= pend_t'(pend_q >> {dec.len, 3'b000});
								cnt_q       <= rem;
								if (rem == 3'd0) state_q <= ST_IDLE;
							end
						end
						ACT_PAIR: begin
							// send the high surrogate, hold the low one
							if (out_free) begin
								unit_q      <= dec.unit_hi;
								unit_last_q <= 1'b0;
								lo_q        <= dec.unit_lo;
								pend_q      <= pend_t'(pend_q >> {dec.len, 3'b000});
								cnt_q       <= rem;
								state_q     <= ST_LO;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_LO: begin
					if (out_free) begin
						unit_q      <= lo_q;
						unit_last_q <= last_q && cnt_q == 3'd0;
						state_q     <= (cnt_q == 3'd0) ? ST_IDLE : ST_STEP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// buffer never overflows
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("pending byte count above four");

	// an item is taken only with room left in the buffer
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> cnt_q < 3'd4)
		else $error("item taken with a full buffer");

	// the unit after a high surrogate is a low surrogate
	a_lo_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LO && out_free) |=> (out_valid && code_unit[15:10] == LO_PREFIX))
		else $error("low surrogate missing after high surrogate");

	// no string end is flagged while bytes remain buffered from that item
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && out_free) ##1 (out_valid && unit_last && $changed(unit_q)
			&& state_q == ST_IDLE) |-> cnt_q == 3'd0)
		else $error("final unit flagged with bytes still pending");

endmodule

>>> rtl/u8u16_decode.sv
module u8u16_decode import u8u16_pkg::*; (
	input  pend_t      pend,
	input  logic [2:0] cnt,
	input  logic       last,
	output dec_t       dec
);

	logic [2:0]  len;
	logic        cont_ok;
	logic [20:0] cp;
	logic [20:0] cp_off;

	// classify the lead and check the continuation bytes it announces
	always_comb begin
		len = lead_len(pend[0]);
		cont_ok = 1'b1;
		for (int j = 1; j < 4; j++) begin
			if (3'(j) < len && pend[j][7:6] != 2'b10) cont_ok = 1'b0;
		end
	end

	// assemble the code point
	always_comb begin
		case (len)
			3'd1: cp = {13'd0, pend[0]};
			3'd2: cp = {10'd0, pend[0][4:0], pend[1][5:0]};
			3'd3: cp = {5'd0, pend[0][3:0], pend[1][5:0], pend[2][5:0]};
			3'd4: cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], pend[3][5:0]};
			default: cp = '0;
		endcase
		cp_off = cp - SUPP_BASE;
	end

	// pick the action and the units
	always_comb begin
		dec.len     = len;
		dec.unit_hi = REPL_UNIT;
		dec.unit_lo = {LO_PREFIX, cp_off[9:0]};
		if (len == 3'd0) begin
			dec.act = ACT_BAD;
		end else if (cnt < len) begin
			dec.act = last ? ACT_CUT : ACT_WAIT;
		end else if (!cont_ok || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
			dec.act = ACT_BAD;
		end else if (cp <= BMP_MAX) begin
			dec.act     = ACT_ONE;
			dec.unit_hi = cp[15:0];
		end else begin
			dec.act     = ACT_PAIR;
			dec.unit_hi = {HI_PREFIX, cp_off[19:10]};
		end
	end

endmodule
